FILE: sv/oale_pkg.sv
package oale_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_INSERT       = 3'd1,
        OP_FIND         = 3'd2,
        OP_REMOVE_VALUE = 3'd3,
        OP_REMOVE_AT    = 3'd4,
        OP_READ         = 3'd5,
        OP_WRITE        = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CC_HOLD       = 2'd0,
        CC_LOAD       = 2'd1,
        CC_FROM_LEFT  = 2'd2,
        CC_FROM_RIGHT = 2'd3
    } t_cell_cmd;

endpackage

FILE: sv/ordered_array_list_engine.sv
// Ordered array list engine: a dense list of up to 64 signed 32-bit values
// held in a row of cells, each cell able to load, hold, or take its left or
// right neighbor's value every cycle.
// Request channel: i_op, i_position, i_value are taken at a rising edge with
// i_start high and o_busy low. o_busy is high while a request executes.
// Result channel: o_done is high for one cycle with o_status, o_read_data,
// o_found, o_found_index and o_element_count; the receiver cannot stall, so
// nothing is held back.
// Timing: the accepting edge moves the FSM to S_EXEC, and the edge that ends
// S_EXEC sets o_done and loads the result registers; o_busy is low while o_done
// is high, so a new request can be accepted at the edge that ends o_done.
// A new request waits until the last one is through. remove_value stays in
// S_EXEC while a match remains: the cell row drops the first match per cycle
// with a left shift, the match prefix running along the row.
// Reset (synchronous, active low) empties the list; cell contents are left
// as they are and are never observed until written.
module ordered_array_list_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [2:0]                   i_op,
    input  logic [5:0]                   i_position,
    input  logic signed [31:0]           i_value,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic signed [31:0]           o_read_data,
    output logic                         o_found,
    output logic [5:0]                   o_found_index,
    output logic [6:0]                   o_element_count
);

    localparam int CAP = oale_pkg::CAPACITY;
    localparam int DW  = oale_pkg::DATA_W;
    localparam int IW  = oale_pkg::IDX_W;
    localparam int CW  = oale_pkg::CNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_done, n_done;
    oale_pkg::t_op       r_op;
    logic [IW-1:0]       r_pos;
    logic [DW-1:0]       r_val;
    oale_pkg::t_status   r_status, n_status;
    logic [DW-1:0]       r_rdata, n_rdata;
    logic                r_found, n_found;
    logic [IW-1:0]       r_fidx, n_fidx;

    logic [DW-1:0]       w_data  [CAP];
    logic [CAP-1:0]      w_match;
    logic [CAP-1:0]      w_pre;
    logic [CAP-1:0]      w_first;
    oale_pkg::t_cell_cmd w_cmd   [CAP];
    logic [CW-1:0]       w_pos;
    logic                w_full;
    logic                w_pos_lt;
    logic                w_pos_le;
    logic                w_exec;
    logic [DW-1:0]       w_rsel;
    logic [IW-1:0]       w_fenc;

    assign w_pos    = CW'(r_pos);
    assign w_full   = (r_cnt >= CAP_C);
    assign w_pos_lt = (w_pos < r_cnt);
    assign w_pos_le = (w_pos <= r_cnt);
    assign w_exec   = (r_state == S_EXEC);

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            localparam logic [CW-1:0] K  = CW'(g);
            logic [DW-1:0] w_left;
            logic [DW-1:0] w_right;

            if (g == 0) begin : g_first
                assign w_left      = r_val;
                assign w_pre[g]    = w_match[g];
                assign w_first[g]  = w_match[g];
            end else begin : g_rest
                assign w_left      = w_data[g-1];
                assign w_pre[g]    = w_pre[g-1] | w_match[g];
                assign w_first[g]  = w_match[g] & ~w_pre[g-1];
            end

            if (g == CAP - 1) begin : g_last
                assign w_right = r_val;
            end else begin : g_inner
                assign w_right = w_data[g+1];
            end

            always_comb begin
                w_cmd[g] = oale_pkg::CC_HOLD;
                if (w_exec) begin
                    unique case (r_op)
                        oale_pkg::OP_APPEND: begin
                            if (!w_full && K == r_cnt) w_cmd[g] = oale_pkg::CC_LOAD;
                        end
                        oale_pkg::OP_INSERT: begin
                            if (!w_full && w_pos_le) begin
                                if (K > w_pos)       w_cmd[g] = oale_pkg::CC_FROM_LEFT;
                                else if (K == w_pos) w_cmd[g] = oale_pkg::CC_LOAD;
                            end
                        end
                        oale_pkg::OP_REMOVE_VALUE: begin
                            if (w_pre[g]) w_cmd[g] = oale_pkg::CC_FROM_RIGHT;
                        end
                        oale_pkg::OP_REMOVE_AT: begin
                            if (w_pos_lt && K >= w_pos) w_cmd[g] = oale_pkg::CC_FROM_RIGHT;
                        end
                        oale_pkg::OP_WRITE: begin
                            if (w_pos_lt && K == w_pos) w_cmd[g] = oale_pkg::CC_LOAD;
                        end
                        default: w_cmd[g] = oale_pkg::CC_HOLD;
                    endcase
                end
            end

            oale_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_valid (K < r_cnt),
                .i_value (r_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        w_rsel = '0;
        w_fenc = '0;
        for (int i = 0; i < CAP; i++) begin
            if (r_pos == IW'(i)) w_rsel = w_rsel | w_data[IW'(i)];
            if (w_first[i])      w_fenc = w_fenc | IW'(i);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_status = oale_pkg::ST_OK;
        n_rdata  = '0;
        n_found  = 1'b0;
        n_fidx   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                unique case (r_op)
                    oale_pkg::OP_APPEND: begin
                        if (w_full) n_status = oale_pkg::ST_FULL;
                        else        n_cnt    = r_cnt + 1'b1;
                    end
                    oale_pkg::OP_INSERT: begin
                        if (w_full)         n_status = oale_pkg::ST_FULL;
                        else if (!w_pos_le) n_status = oale_pkg::ST_RANGE;
                        else                n_cnt    = r_cnt + 1'b1;
                    end
                    oale_pkg::OP_FIND: begin
                        n_found = w_pre[CAP-1];
                        n_fidx  = w_fenc;
                    end
                    oale_pkg::OP_REMOVE_VALUE: begin
                        if (w_pre[CAP-1]) begin
                            n_cnt   = r_cnt - 1'b1;
                            n_state = S_EXEC;
                            n_done  = 1'b0;
                        end
                    end
                    oale_pkg::OP_REMOVE_AT: begin
                        if (w_pos_lt) n_cnt    = r_cnt - 1'b1;
                        else          n_status = oale_pkg::ST_RANGE;
                    end
                    oale_pkg::OP_READ: begin
                        if (w_pos_lt) begin
                            n_rdata = w_rsel;
                        end else begin
                            n_status = oale_pkg::ST_RANGE;
                            n_rdata  = '1;
                        end
                    end
                    oale_pkg::OP_WRITE: begin
                        if (!w_pos_lt) n_status = oale_pkg::ST_RANGE;
                    end
                    default: n_status = oale_pkg::ST_OK;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op  <= oale_pkg::t_op'(i_op);
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
    end

    assign o_busy          = w_exec;
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_read_data     = r_rdata;
    assign o_found         = r_found;
    assign o_found_index   = r_fidx;
    assign o_element_count = r_cnt;

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an executing request");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_C)
        else $error("element count above capacity");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> (r_cnt == $past(r_cnt) || r_cnt == $past(r_cnt) + 1'b1
                    || r_cnt == $past(r_cnt) - 1'b1))
        else $error("element count changed by more than one");

    a_idle_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_cnt))
        else $error("element count changed while idle");

endmodule

FILE: sv/oale_cell.sv
module oale_cell (
    input  logic                          i_clk,
    input  oale_pkg::t_cell_cmd           i_cmd,
    input  logic                          i_valid,
    input  logic [oale_pkg::DATA_W-1:0]   i_value,
    input  logic [oale_pkg::DATA_W-1:0]   i_left,
    input  logic [oale_pkg::DATA_W-1:0]   i_right,
    output logic [oale_pkg::DATA_W-1:0]   o_data,
    output logic                          o_match
);

    logic [oale_pkg::DATA_W-1:0] r_data;
    logic [oale_pkg::DATA_W-1:0] n_data;

    always_comb begin
        unique case (i_cmd)
            oale_pkg::CC_LOAD:       n_data = i_value;
            oale_pkg::CC_FROM_LEFT:  n_data = i_left;
            oale_pkg::CC_FROM_RIGHT: n_data = i_right;
            default:                 n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_valid && (r_data == i_value);

endmodule

FILE: verif/tb_ordered_array_list_engine.sv
`timescale 1ns / 100ps

module tb_ordered_array_list_engine;

    localparam logic [2:0]        OP_UNUSED    = 3'd7;
    localparam logic signed [31:0] READ_MISS   = -32'sd1;
    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                SETTLE_CYCLES = 8;
    localparam int                BATCHES      = 18;
    localparam int                BATCH_ITEMS  = 25;

    typedef enum int {PH_GROW = 0, PH_FULL = 1, PH_SHRINK = 2} t_phase;

    // pick weights per phase in percent, indexed by op code (7 = unused)
    localparam int OP_WEIGHT [3][8] = '{
        '{40, 35,  6,  6,  6,  3,  2, 2},
        '{20, 20, 15, 15, 14,  8,  6, 2},
        '{ 8,  8, 10, 10, 10, 34, 18, 2}
    };

    typedef struct {
        logic [2:0]         op;
        logic [5:0]         position;
        logic signed [31:0] value;
        bit                 drain;
    } t_list_request;

    typedef struct {
        oale_pkg::t_status  status;
        logic signed [31:0] read_data;
        logic               found;
        logic [5:0]         found_index;
        logic [6:0]         element_count;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               i_start    = 1'b0;
    logic [2:0]         i_op       = '0;
    logic [5:0]         i_position = '0;
    logic signed [31:0] i_value    = '0;
    logic               o_busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [31:0] o_read_data;
    logic               o_found;
    logic [5:0]         o_found_index;
    logic [6:0]         o_element_count;

    t_list_request      request_queue[$];
    t_list_result       expected_results[$];
    logic signed [31:0] list_cells[oale_pkg::CAPACITY];
    int                 list_count    = 0;
    int                 mismatch_count = 0;
    int                 cycle_count   = 0;
    logic               request_taken = 1'b0;
    bit                 quiet_stretch = 1'b0;

    ordered_array_list_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_op            (i_op),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_element_count (o_element_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_op(logic [2:0] op, logic [5:0] pos,
                                                   logic signed [31:0] val);
        t_list_result r;
        int           i;
        int           w;
        r.status      = oale_pkg::ST_OK;
        r.read_data   = '0;
        r.found       = 1'b0;
        r.found_index = '0;
        unique case (op)
            oale_pkg::OP_APPEND: begin
                if (list_count >= oale_pkg::CAPACITY) begin
                    r.status = oale_pkg::ST_FULL;
                end else begin
                    list_cells[6'(list_count)] = val;
                    list_count++;
                end
            end
            oale_pkg::OP_INSERT: begin
                if (list_count >= oale_pkg::CAPACITY) begin
                    r.status = oale_pkg::ST_FULL;
                end else if (pos > list_count) begin
                    r.status = oale_pkg::ST_RANGE;
                end else begin
                    for (i = list_count; i > pos; i--)
                        list_cells[6'(i)] = list_cells[6'(i - 1)];
                    list_cells[pos] = val;
                    list_count++;
                end
            end
            oale_pkg::OP_FIND: begin
                for (i = 0; i < list_count; i++) begin
                    if (list_cells[6'(i)] == val && !r.found) begin
                        r.found       = 1'b1;
                        r.found_index = i[5:0];
                    end
                end
            end
            oale_pkg::OP_REMOVE_VALUE: begin
                w = 0;
                for (i = 0; i < list_count; i++) begin
                    if (list_cells[6'(i)] != val) begin
                        list_cells[6'(w)] = list_cells[6'(i)];
                        w++;
                    end
                end
                list_count = w;
            end
            oale_pkg::OP_REMOVE_AT: begin
                if (pos >= list_count) begin
                    r.status = oale_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_cells[6'(i)] = list_cells[6'(i + 1)];
                    list_count--;
                end
            end
            oale_pkg::OP_READ: begin
                if (pos >= list_count) begin
                    r.status    = oale_pkg::ST_RANGE;
                    r.read_data = READ_MISS;
                end else begin
                    r.read_data = list_cells[pos];
                end
            end
            oale_pkg::OP_WRITE: begin
                if (pos >= list_count)
                    r.status = oale_pkg::ST_RANGE;
                else
                    list_cells[pos] = val;
            end
            default: ;
        endcase
        r.element_count = list_count[6:0];
        return r;
    endfunction

    task automatic queue_request(logic [2:0] op, logic [5:0] pos, logic signed [31:0] val,
                                 bit drain);
        t_list_request req;
        req.op       = op;
        req.position = pos;
        req.value    = val;
        req.drain    = drain;
        request_queue.push_back(req);
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || expected_results.size() != 0 || i_start)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin : drive_proc
        logic          launch;
        t_list_request nxt;
        launch = 1'b0;
        if (i_rst_n) begin
            if (i_start && !request_taken) begin
                launch = 1'b1;
            end else begin
                if (request_taken)
                    request_queue.delete(0);
                if (request_queue.size() > 0) begin
                    if (request_queue[0].drain && expected_results.size() != 0)
                        launch = 1'b0;
                    else if (!quiet_stretch && $urandom_range(99) < 7)
                        launch = 1'b0;
                    else
                        launch = 1'b1;
                end
            end
        end
        if (launch) begin
            nxt = request_queue[0];
            i_op       <= nxt.op;
            i_position <= nxt.position;
            i_value    <= nxt.value;
        end
        i_start <= launch;
    end

    // monitor
    always @(posedge i_clk) begin : monitor_proc
        t_list_result exp_r;
        logic         taken;
        taken = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d count %0d", o_status,
                           o_element_count);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                        mismatch_count++;
                    end
                    if (o_read_data !== exp_r.read_data) begin
                        $error("read_data: expected %0d, actual %0d", exp_r.read_data,
                               o_read_data);
                        mismatch_count++;
                    end
                    if (o_found !== exp_r.found) begin
                        $error("found: expected %0d, actual %0d", exp_r.found, o_found);
                        mismatch_count++;
                    end
                    if (o_found_index !== exp_r.found_index) begin
                        $error("found_index: expected %0d, actual %0d", exp_r.found_index,
                               o_found_index);
                        mismatch_count++;
                    end
                    if (o_element_count !== exp_r.element_count) begin
                        $error("element_count: expected %0d, actual %0d",
                               exp_r.element_count, o_element_count);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                expected_results.push_back(apply_list_op(i_op, i_position, i_value));
                taken = 1'b1;
            end
        end
        request_taken <= taken;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    logic signed [31:0] value_pool[6] = '{32'sd0, -32'sd1, 32'sd1, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'sd42};

    initial begin : stimulus_proc
        t_phase             phase;
        int                 batch;
        int                 n;
        int                 k;
        int                 acc;
        int                 roll;
        int                 est;
        logic [5:0]         pos;
        logic signed [31:0] val;

        // empty list corner cases
        queue_request(oale_pkg::OP_READ,         6'd0,  32'sd7,        1'b0);
        queue_request(oale_pkg::OP_READ,         6'd63, 32'sd7,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_AT,    6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_WRITE,        6'd0,  32'sd9,        1'b0);
        queue_request(oale_pkg::OP_FIND,         6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_VALUE, 6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_INSERT,       6'd1,  32'sd3,        1'b0);
        queue_request(OP_UNUSED,                 6'd63, 32'hFFFF_FFFF, 1'b0);
        // build a short list
        queue_request(oale_pkg::OP_INSERT,       6'd0,  32'h7FFF_FFFF, 1'b0);
        queue_request(oale_pkg::OP_APPEND,       6'd63, 32'h8000_0000, 1'b0);
        queue_request(oale_pkg::OP_APPEND,       6'd0,  -32'sd1,       1'b0);
        queue_request(oale_pkg::OP_INSERT,       6'd3,  32'sd5,        1'b0);
        queue_request(oale_pkg::OP_INSERT,       6'd1,  32'sd5,        1'b0);
        queue_request(oale_pkg::OP_FIND,         6'd0,  32'sd5,        1'b1);
        queue_request(oale_pkg::OP_FIND,         6'd0,  32'sd123,      1'b0);
        queue_request(oale_pkg::OP_READ,         6'd4,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_WRITE,        6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_READ,         6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_WRITE,        6'd63, 32'sd1,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_AT,    6'd5,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_AT,    6'd0,  32'sd0,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_VALUE, 6'd0,  32'sd5,        1'b0);
        queue_request(oale_pkg::OP_REMOVE_VALUE, 6'd0,  32'sd99,       1'b0);
        queue_request(oale_pkg::OP_REMOVE_AT,    6'd1,  32'sd0,        1'b0);
        queue_request(OP_UNUSED,                 6'd0,  32'sd0,        1'b1);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_idle();
        phase = PH_GROW;
        for (batch = 0; batch < BATCHES; batch++) begin
            quiet_stretch = (batch >= 6 && batch < 10);
            est = list_count;
            for (n = 0; n < BATCH_ITEMS; n++) begin
                roll = $urandom_range(99);
                k    = 0;
                acc  = OP_WEIGHT[2'(phase)][3'(0)];
                while (roll >= acc) begin
                    k++;
                    acc += OP_WEIGHT[2'(phase)][3'(k)];
                end
                if ($urandom_range(99) < 85) begin
                    if (k == oale_pkg::OP_INSERT)
                        pos = 6'($urandom_range((est > 63) ? 63 : est));
                    else
                        pos = (est == 0) ? 6'd0 : 6'($urandom_range(est - 1));
                end else begin
                    pos = 6'($urandom_range(63));
                end
                if ($urandom_range(99) < 60)
                    val = value_pool[3'($urandom_range(5))];
                else
                    val = $urandom;
                if (k == oale_pkg::OP_APPEND && est < oale_pkg::CAPACITY)
                    est++;
                else if (k == oale_pkg::OP_INSERT && est < oale_pkg::CAPACITY && pos <= est)
                    est++;
                else if (k == oale_pkg::OP_REMOVE_AT && pos < est)
                    est--;
                else if (k == oale_pkg::OP_REMOVE_VALUE && est > 0)
                    est--;
                queue_request(k[2:0], pos, val, $urandom_range(49) == 0);
            end
            wait_idle();
            unique case (phase)
                PH_GROW:   if (list_count >= oale_pkg::CAPACITY) phase = PH_FULL;
                PH_FULL:   phase = PH_SHRINK;
                PH_SHRINK: if (list_count <= 2) phase = PH_GROW;
                default:   phase = PH_GROW;
            endcase
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
